// File: hw/rtl/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned FIELD_ADDR_W = 32;
  localparam int unsigned BYTES_W      = 16;
  localparam int unsigned COUNT_W      = 9;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES = 16'd4;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

  typedef logic [FIELD_ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

endpackage

// File: hw/rtl/fixed_block_pool_allocator.sv
// Top level: fixed-size block pool allocator with a shifting LIFO of freed blocks.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | input     | in_valid/in_stall  | in_cmd, in_free_address
//  out     | output    | out_valid/out_stall| out_block_address, out_status, out_blocks_free
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each accepted request's result sits in the output register in the next cycle.
// A new request is taken every cycle while the output register is free or being drained.
// Pop and push move the whole cell chain by one position in that same cycle.
// Reset empties the pool and clears the geometry; cfg_ready is always high.
// A stalled result blocks the input only while out_stall holds it.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [fbpa_pkg::CMD_W-1:0]            in_cmd,
  input  logic [fbpa_pkg::FIELD_ADDR_W-1:0]     in_free_address,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [fbpa_pkg::FIELD_ADDR_W-1:0]     out_block_address,
  output logic [fbpa_pkg::STATUS_W-1:0]         out_status,
  output logic [fbpa_pkg::COUNT_W-1:0]          out_blocks_free,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fbpa_pkg::FIELD_ADDR_W-1:0]     cfg_data
);
  import fbpa_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PROD_W = CNT_W + BYTES_W;
  localparam int unsigned END_W  = ((PROD_W > FIELD_ADDR_W) ? PROD_W : FIELD_ADDR_W) + 1;

  logic [FIELD_ADDR_W-1:0] cfg_base_r;
  logic [BYTES_W-1:0]      cfg_bytes_r;
  logic [COUNT_W-1:0]      cfg_count_r;

  logic [FIELD_ADDR_W-1:0] pool_base_r,  pool_base_nxt;
  logic [BYTES_W-1:0]      pool_size_r,  pool_size_nxt;
  logic [CNT_W-1:0]        pool_count_r, pool_count_nxt;
  logic [END_W-1:0]        pool_end_r,   pool_end_nxt;
  logic [CNT_W-1:0]        depth_r,      depth_nxt;
  logic [CNT_W-1:0]        fresh_rem_r,  fresh_rem_nxt;
  logic [ADDR_WIDTH-1:0]   fresh_addr_r, fresh_addr_nxt;

  logic                    out_valid_r;
  logic [FIELD_ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [COUNT_W-1:0]      res_free_r, res_free_nxt;

  logic                    accept;
  stk_op_t                 stk_op;
  addr_t                   stk_top;
  logic [BYTES_W-1:0]      init_size;
  logic [CNT_W-1:0]        init_count;
  logic [PROD_W-1:0]       init_span;
  logic [CNT_W:0]          free_now;
  logic [CNT_W:0]          free_after;
  logic [END_W-1:0]        req_addr_ext;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r  <= '0;
      cfg_bytes_r <= MIN_BLOCK_BYTES;
      cfg_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS: cfg_base_r  <= cfg_data;
        CFG_BLOCK_BYTES:  cfg_bytes_r <= cfg_data[BYTES_W-1:0];
        CFG_BLOCK_COUNT:  cfg_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign init_size  = (cfg_bytes_r < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg_bytes_r;
  assign init_count = (32'(cfg_count_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                           : CNT_W'(cfg_count_r);
  assign init_span  = PROD_W'(init_count) * PROD_W'(init_size);
  assign free_now   = {1'b0, depth_r} + {1'b0, fresh_rem_r};
  assign req_addr_ext = END_W'(in_free_address);

  always_comb begin
    pool_base_nxt  = pool_base_r;
    pool_size_nxt  = pool_size_r;
    pool_count_nxt = pool_count_r;
    pool_end_nxt   = pool_end_r;
    depth_nxt      = depth_r;
    fresh_rem_nxt  = fresh_rem_r;
    fresh_addr_nxt = fresh_addr_r;
    res_addr_nxt   = '0;
    res_status_nxt = ST_OK;
    stk_op         = '0;
    unique case (in_cmd)
      CMD_INIT: begin
        if (cfg_base_r == '0 || cfg_bytes_r == '0 || cfg_count_r == '0) begin
          res_status_nxt = ST_INVALID;
        end else begin
          pool_base_nxt  = cfg_base_r;
          pool_size_nxt  = init_size;
          pool_count_nxt = init_count;
          pool_end_nxt   = END_W'(cfg_base_r) + END_W'(init_span);
          depth_nxt      = '0;
          fresh_rem_nxt  = init_count;
          fresh_addr_nxt = ADDR_WIDTH'(cfg_base_r);
        end
      end
      CMD_ALLOC: begin
        if (depth_r != '0) begin
          depth_nxt    = depth_r - CNT_W'(1);
          res_addr_nxt = stk_top;
          stk_op.pop   = accept;
        end else if (fresh_rem_r != '0) begin
          res_addr_nxt   = FIELD_ADDR_W'(fresh_addr_r);
          fresh_addr_nxt = fresh_addr_r + ADDR_WIDTH'(pool_size_r);
          fresh_rem_nxt  = fresh_rem_r - CNT_W'(1);
        end else begin
          res_status_nxt = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        if (in_free_address == '0 || req_addr_ext < END_W'(pool_base_r) ||
            req_addr_ext >= pool_end_r) begin
          res_status_nxt = ST_INVALID;
        end else if (free_now >= {1'b0, pool_count_r} ||
                     {1'b0, depth_r} >= (CNT_W+1)'(MAX_BLOCKS)) begin
          res_status_nxt = ST_FULL;
        end else begin
          depth_nxt   = depth_r + CNT_W'(1);
          stk_op.push = accept;
        end
      end
      default: begin
        res_status_nxt = ST_INVALID;
      end
    endcase
    free_after   = {1'b0, depth_nxt} + {1'b0, fresh_rem_nxt};
    res_free_nxt = COUNT_W'(free_after);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      pool_size_r  <= '0;
      pool_count_r <= '0;
      pool_end_r   <= '0;
      depth_r      <= '0;
      fresh_rem_r  <= '0;
      fresh_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        pool_base_r  <= pool_base_nxt;
        pool_size_r  <= pool_size_nxt;
        pool_count_r <= pool_count_nxt;
        pool_end_r   <= pool_end_nxt;
        depth_r      <= depth_nxt;
        fresh_rem_r  <= fresh_rem_nxt;
        fresh_addr_r <= fresh_addr_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_addr_r   <= res_addr_nxt;
      res_status_r <= res_status_nxt;
      res_free_r   <= res_free_nxt;
    end
  end

  fbpa_stack #(
    .DEPTH(MAX_BLOCKS)
  ) u_stack (
    .clk      (clk),
    .op       (stk_op),
    .push_data(in_free_address),
    .top_data (stk_top)
  );

  assign out_valid         = out_valid_r;
  assign out_block_address = res_addr_r;
  assign out_status        = res_status_r;
  assign out_blocks_free   = res_free_r;

endmodule

// File: hw/rtl/fbpa_cell.sv
// One stack cell: holds one freed address and shifts with its neighbors.
module fbpa_cell (
  input  logic             clk,
  input  fbpa_pkg::stk_op_t op,
  input  fbpa_pkg::addr_t  from_above,
  input  fbpa_pkg::addr_t  from_below,
  output fbpa_pkg::addr_t  data
);
  import fbpa_pkg::*;

  addr_t data_r;
  addr_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (op.push) begin
      data_nxt = from_above;
    end else if (op.pop) begin
      data_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: hw/rtl/fbpa_stack.sv
// Chain of stack cells; the top of the freed-address stack sits in cell 0.
module fbpa_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  logic              clk,
  input  fbpa_pkg::stk_op_t op,
  input  fbpa_pkg::addr_t   push_data,
  output fbpa_pkg::addr_t   top_data
);
  import fbpa_pkg::*;

  addr_t cell_q [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      addr_t above;
      addr_t below;
      if (i == 0) begin : g_first
        assign above = push_data;
      end else begin : g_mid
        assign above = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign below = '0;
      end else begin : g_inner
        assign below = cell_q[i+1];
      end
      fbpa_cell u_cell (
        .clk       (clk),
        .op        (op),
        .from_above(above),
        .from_below(below),
        .data      (cell_q[i])
      );
    end
  endgenerate

  assign top_data = cell_q[0];

endmodule
